// ===== hw/rtl/rgb_box_downscaler_defines.svh =====
// Assertion helpers shared by the downscaler modules.
// Each expects clk and rst_n in the scope where it is used.
`ifndef RGB_BOX_DOWNSCALER_DEFINES_SVH
`define RGB_BOX_DOWNSCALER_DEFINES_SVH

// Same-cycle implication.
`define RBD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rbd_pkg.sv =====
package rbd_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MAX_FACTOR  = 8;

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int PHASE_W     = $clog2(MAX_FACTOR);
    localparam int SUM_W       = 14;
    localparam int FW_W        = 12;
    localparam int FH_W        = 13;
    localparam int SF_W        = 4;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int RECIP_SHIFT = 21;
    localparam int RECIP_W     = 22;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_SHRINK_FACTOR = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_done;
    } pix_out_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } sums_t;

    // Per-pixel control from the raster counters to the accumulator
    typedef struct packed {
        logic             active;
        logic             first;
        logic             last;
        logic             done;
        logic [COL_W-1:0] col;
    } tap_t;

    // ceil(2^21 / (f*f)) for f = 1..8; exact floor division of any 14-bit sum
    localparam logic [RECIP_W-1:0] RECIP_TABLE [MAX_FACTOR] = '{
        22'd2097152, 22'd524288, 22'd233017, 22'd131072,
        22'd83887,   22'd58255,  22'd42800,  22'd32768
    };

endpackage

// ===== hw/rtl/rbd_raster.sv =====
`include "rgb_box_downscaler_defines.svh"

module rbd_raster (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbd_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           take,
    output rbd_pkg::tap_t                  tap,
    output logic [rbd_pkg::PHASE_W-1:0]    fm1
);
    import rbd_pkg::*;

    logic [FW_W-1:0]    fw_reg;
    logic [FH_W-1:0]    fh_reg;
    logic [SF_W-1:0]    sf_reg;

    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [PHASE_W-1:0] hph_reg, hph_next;
    logic [PHASE_W-1:0] vph_reg, vph_next;
    logic [COL_W-1:0]   ocol_reg, ocol_next;
    logic [COL_W-1:0]   h_start_reg, h_start_next;
    logic [ROW_W-1:0]   v_start_reg, v_start_next;

    logic [FW_W-1:0]    width_c;
    logic [FH_W-1:0]    height_c;
    logic [SF_W-1:0]    factor_c;
    logic               restart;
    logic [FW_W:0]      h_end1, h_end2;
    logic [FH_W:0]      v_end1, v_end2;
    logic               h_fit, h_lastsq, v_fit, v_lastsq;
    logic               col_end, row_end;

    // Clamp registers to their legal ranges
    always_comb
    begin
        if (fw_reg == '0)
            width_c = FW_W'(1);
        else if (fw_reg > FW_W'(MAX_WIDTH))
            width_c = FW_W'(MAX_WIDTH);
        else
            width_c = fw_reg;

        if (fh_reg == '0)
            height_c = FH_W'(1);
        else if (fh_reg > FH_W'(MAX_HEIGHT))
            height_c = FH_W'(MAX_HEIGHT);
        else
            height_c = fh_reg;

        if (sf_reg == '0)
            factor_c = SF_W'(1);
        else if (sf_reg > SF_W'(MAX_FACTOR))
            factor_c = SF_W'(MAX_FACTOR);
        else
            factor_c = sf_reg;
    end

    assign fm1 = PHASE_W'(factor_c - SF_W'(1));

    assign restart = cfg_wr_en && (cfg_index == REG_FRAME_WIDTH ||
                                   cfg_index == REG_FRAME_HEIGHT ||
                                   cfg_index == REG_SHRINK_FACTOR);

    // A square fits when its far edge stays inside the frame; it is the last one
    // in its row or column when the following square would not fit
    assign h_end1   = (FW_W+1)'(h_start_reg) + (FW_W+1)'(factor_c);
    assign h_end2   = h_end1 + (FW_W+1)'(factor_c);
    assign h_fit    = h_end1 <= (FW_W+1)'(width_c);
    assign h_lastsq = h_end2 > (FW_W+1)'(width_c);
    assign v_end1   = (FH_W+1)'(v_start_reg) + (FH_W+1)'(factor_c);
    assign v_end2   = v_end1 + (FH_W+1)'(factor_c);
    assign v_fit    = v_end1 <= (FH_W+1)'(height_c);
    assign v_lastsq = v_end2 > (FH_W+1)'(height_c);

    assign col_end = FW_W'(col_reg) >= (width_c - FW_W'(1));
    assign row_end = FH_W'(row_reg) >= (height_c - FH_W'(1));

    always_comb
    begin
        tap.active = h_fit && v_fit;
        tap.first  = (hph_reg == '0) && (vph_reg == '0);
        tap.last   = (hph_reg == fm1) && (vph_reg == fm1);
        tap.done   = h_lastsq && v_lastsq && (vph_reg == fm1);
        tap.col    = ocol_reg;
    end

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        hph_next     = hph_reg;
        vph_next     = vph_reg;
        ocol_next    = ocol_reg;
        h_start_next = h_start_reg;
        v_start_next = v_start_reg;
        if (restart)
        begin
            col_next     = '0;
            row_next     = '0;
            hph_next     = '0;
            vph_next     = '0;
            ocol_next    = '0;
            h_start_next = '0;
            v_start_next = '0;
        end
        else if (take)
        begin
            if (col_end)
            begin
                col_next     = '0;
                hph_next     = '0;
                ocol_next    = '0;
                h_start_next = '0;
                if (row_end)
                begin
                    row_next     = '0;
                    vph_next     = '0;
                    v_start_next = '0;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                    if (vph_reg >= fm1)
                    begin
                        vph_next     = '0;
                        v_start_next = row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        vph_next = vph_reg + PHASE_W'(1);
                    end
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
                if (hph_reg >= fm1)
                begin
                    hph_next     = '0;
                    ocol_next    = ocol_reg + COL_W'(1);
                    h_start_next = col_reg + COL_W'(1);
                end
                else
                begin
                    hph_next = hph_reg + PHASE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg      <= FW_W'(1920);
            fh_reg      <= FH_W'(1080);
            sf_reg      <= SF_W'(2);
            col_reg     <= '0;
            row_reg     <= '0;
            hph_reg     <= '0;
            vph_reg     <= '0;
            ocol_reg    <= '0;
            h_start_reg <= '0;
            v_start_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:   fw_reg <= cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT:  fh_reg <= cfg_data[FH_W-1:0];
                    REG_SHRINK_FACTOR: sf_reg <= cfg_data[SF_W-1:0];
                    default:           ;
                endcase
            end
            col_reg     <= col_next;
            row_reg     <= row_next;
            hph_reg     <= hph_next;
            vph_reg     <= vph_next;
            ocol_reg    <= ocol_next;
            h_start_reg <= h_start_next;
            v_start_reg <= v_start_next;
        end
    end

    `RBD_ASSERT_IMPL(a_hph_range, 1'b1, hph_reg <= fm1, "horizontal phase beyond factor")
    `RBD_ASSERT_IMPL(a_vph_range, 1'b1, vph_reg <= fm1, "vertical phase beyond factor")

endmodule

// ===== hw/rtl/rbd_accum.sv =====
`include "rgb_box_downscaler_defines.svh"

module rbd_accum (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              take,
    input  rbd_pkg::tap_t     tap,
    input  rbd_pkg::pix_in_t  pix,
    output logic              res_valid,
    output rbd_pkg::sums_t    res_sums,
    output logic              res_done
);
    import rbd_pkg::*;

    sums_t    sum_mem [MAX_WIDTH];

    logic     s1_valid_reg;
    tap_t     s1_tap_reg;
    pix_in_t  s1_pix_reg;
    sums_t    rd_data_reg;
    logic     fwd_valid_reg;
    logic [COL_W-1:0] fwd_col_reg;
    sums_t    fwd_data_reg;
    logic     s2_valid_reg;
    sums_t    s2_sums_reg;
    logic     s2_done_reg;

    sums_t    base;
    sums_t    acc_sum;
    logic     wr_en;

    // The entry written on the edge that issued this read is still stale in the RAM
    assign base = (fwd_valid_reg && fwd_col_reg == s1_tap_reg.col) ? fwd_data_reg
                                                                    : rd_data_reg;

    always_comb
    begin
        if (s1_tap_reg.first)
        begin
            acc_sum.red   = SUM_W'(s1_pix_reg.red_in);
            acc_sum.green = SUM_W'(s1_pix_reg.green_in);
            acc_sum.blue  = SUM_W'(s1_pix_reg.blue_in);
        end
        else
        begin
            acc_sum.red   = SUM_W'(base.red + SUM_W'(s1_pix_reg.red_in));
            acc_sum.green = SUM_W'(base.green + SUM_W'(s1_pix_reg.green_in));
            acc_sum.blue  = SUM_W'(base.blue + SUM_W'(s1_pix_reg.blue_in));
        end
    end

    assign wr_en = adv && s1_valid_reg && s1_tap_reg.active;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            sum_mem[s1_tap_reg.col] <= acc_sum;
        if (take && tap.active)
            rd_data_reg <= sum_mem[tap.col];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= take;
            fwd_valid_reg <= wr_en;
            s2_valid_reg  <= s1_valid_reg && s1_tap_reg.active && s1_tap_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tap_reg   <= tap;
            s1_pix_reg   <= pix;
            fwd_col_reg  <= s1_tap_reg.col;
            fwd_data_reg <= acc_sum;
            s2_sums_reg  <= acc_sum;
            s2_done_reg  <= s1_tap_reg.done;
        end
    end

    assign res_valid = s2_valid_reg;
    assign res_sums  = s2_sums_reg;
    assign res_done  = s2_done_reg;

    `RBD_ASSERT_NEXT(a_hold_result, !adv && s2_valid_reg,
        s2_valid_reg && $stable(s2_sums_reg), "finished square lost while stalled")
    `RBD_ASSERT_IMPL(a_take_adv, take, adv, "pixel taken during stall")

endmodule

// ===== hw/rtl/rbd_average.sv =====
`include "rgb_box_downscaler_defines.svh"

module rbd_average (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [rbd_pkg::PHASE_W-1:0]  fm1,
    input  logic                         res_valid,
    input  rbd_pkg::sums_t               res_sums,
    input  logic                         res_done,
    input  logic                         out_ready,
    output logic                         out_valid,
    output rbd_pkg::pix_out_t            out_data,
    output logic                         load
);
    import rbd_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W;

    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod_r, prod_g, prod_b;
    logic               out_valid_reg;
    pix_out_t           out_data_reg;

    // Divide by factor squared: multiply by a rounded-up reciprocal, keep the integer part
    assign recip  = RECIP_TABLE[fm1];
    assign prod_r = PROD_W'(res_sums.red) * PROD_W'(recip);
    assign prod_g = PROD_W'(res_sums.green) * PROD_W'(recip);
    assign prod_b = PROD_W'(res_sums.blue) * PROD_W'(recip);

    assign load = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            out_data_reg.red_out    <= prod_r[RECIP_SHIFT +: 8];
            out_data_reg.green_out  <= prod_g[RECIP_SHIFT +: 8];
            out_data_reg.blue_out   <= prod_b[RECIP_SHIFT +: 8];
            out_data_reg.frame_done <= res_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `RBD_ASSERT_IMPL(a_quot_range, res_valid,
        (prod_r[PROD_W-1:RECIP_SHIFT+8] == '0) && (prod_g[PROD_W-1:RECIP_SHIFT+8] == '0) &&
        (prod_b[PROD_W-1:RECIP_SHIFT+8] == '0), "average exceeds eight bits")

endmodule

// ===== hw/rtl/rgb_box_downscaler.sv =====
// RGB box downscaler. Pixels enter in raster order and every F-by-F square
// (F = shrink_factor, 1..8) leaves as one pixel holding the truncated
// per-channel average; columns and rows that do not complete a square are
// dropped, and frame_done marks the last output pixel of a frame. One pixel
// is taken every clock; input stalls only while a finished pixel waits in the
// output register and another finished pixel is behind it. A square's sum
// is registered, then its average in the output register. Per-column partial
// sums live in a 2048-entry RAM with a registered read; the read-add-write
// loop on that RAM, with a one-entry bypass for back-to-back hits on the
// same column, sets the one-pixel-per-clock rate. Registers: 0 frame_width,
// 1 frame_height, 2 shrink_factor; a write to any of them restarts the frame.
// The user writes to them only while the block is idle; the block does not enforce it.
module rgb_box_downscaler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  rbd_pkg::pix_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output rbd_pkg::pix_out_t              out_data,
    input  logic                           cfg_wr_en,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbd_pkg::CFG_W-1:0]      cfg_data
);
    import rbd_pkg::*;

    tap_t               tap;
    logic [PHASE_W-1:0] fm1;
    logic               take;
    logic               adv;
    logic               load;
    logic               res_valid;
    sums_t              res_sums;
    logic               res_done;

    // Advance unless a finished pixel is blocked behind a full output
    assign adv      = load || !res_valid;
    assign in_ready = adv;
    assign take     = in_valid && adv;

    rbd_raster u_raster (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .tap       (tap),
        .fm1       (fm1)
    );

    rbd_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .take      (take),
        .tap       (tap),
        .pix       (in_data),
        .res_valid (res_valid),
        .res_sums  (res_sums),
        .res_done  (res_done)
    );

    rbd_average u_average (
        .clk       (clk),
        .rst_n     (rst_n),
        .fm1       (fm1),
        .res_valid (res_valid),
        .res_sums  (res_sums),
        .res_done  (res_done),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .load      (load)
    );

endmodule
